// ===== sv/lcpbt_pkg.sv =====
// Package with shared types and constants for the line command parser and blink timer.
`default_nettype none
package lcpbt_pkg;

    typedef enum logic [3:0] {
        RESP_NONE      = 4'd0,
        RESP_LED_ON    = 4'd1,
        RESP_LED_OFF   = 4'd2,
        RESP_INTERVAL  = 4'd3,
        RESP_TOO_FAST  = 4'd4,
        RESP_BLINK_ON  = 4'd5,
        RESP_HELP      = 4'd6,
        RESP_UNKNOWN   = 4'd7,
        RESP_TOO_LONG  = 4'd8,
        RESP_PROMPT    = 4'd9
    } resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPACE,
        ST_SIGN,
        ST_DIGIT,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_LED_ON,
        ACT_LED_OFF,
        ACT_BLINK
    } act_t;

    localparam logic [29:0] PERIOD_MAX   = 30'd999999999;
    localparam logic [29:0] PERIOD_RESET = 30'd500;

    // Command from controller to datapath.
    typedef struct packed {
        logic       take;
        logic       rd;
        logic       finish;
        logic       send;
    } ctrl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic       scan_done;
    } stat_t;

endpackage
`default_nettype wire

// ===== sv/lcpbt_ctrl.sv =====
// Controller state machine that sequences item intake, line scan and result delivery.
`default_nettype none
module lcpbt_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_acc,
    input  wire logic             out_acc,
    input  wire lcpbt_pkg::stat_t st,
    output lcpbt_pkg::ctrl_t      ctl,
    output logic                  in_ready,
    output logic                  out_busy
);

    lcpbt_pkg::state_t state_reg;
    lcpbt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcpbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_busy   = 1'b0;
        case (state_reg)
            lcpbt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.take = in_acc;
                if (in_acc)
                begin
                    state_next = lcpbt_pkg::ST_SCAN;
                end
            end
            lcpbt_pkg::ST_SCAN:
            begin
                // The scan state walks the line one character per cycle.
                ctl.rd = 1'b1;
                if (st.scan_done)
                begin
                    state_next = lcpbt_pkg::ST_FINISH;
                end
            end
            lcpbt_pkg::ST_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = lcpbt_pkg::ST_OUT;
            end
            lcpbt_pkg::ST_OUT:
            begin
                out_busy = 1'b1;
                ctl.send = out_acc;
                if (out_acc)
                begin
                    state_next = lcpbt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcpbt_pkg::ST_IDLE;
            end
        endcase
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |-> state_reg == lcpbt_pkg::ST_IDLE)
        else $error("item taken outside idle");
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> state_reg == lcpbt_pkg::ST_OUT)
        else $error("finish not followed by output");
    a_send_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.send |=> state_reg == lcpbt_pkg::ST_IDLE)
        else $error("send not followed by idle");

endmodule
`default_nettype wire

// ===== sv/lcpbt_dp.sv =====
// Datapath with line store, command matcher, decimal parser and blink timer.
`default_nettype none
module lcpbt_dp
#(
    parameter int LINE_DEPTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lcpbt_pkg::ctrl_t ctl,
    input  wire logic             op,
    input  wire logic [7:0]       char_in,
    output lcpbt_pkg::stat_t      st,
    output logic                  echo_valid,
    output logic [7:0]            echo_char,
    output logic                  erase,
    output logic [3:0]            response,
    output logic [29:0]           interval_value,
    output logic                  led
);

    localparam int LW = $clog2(LINE_DEPTH);

    logic [7:0]    mem [LINE_DEPTH];
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] idx_reg;
    logic [7:0]    rd_reg;
    logic          rd_ok_reg;
    logic          op_reg;
    logic          end_reg;
    logic          en_reg;
    logic [29:0]   per_reg;
    logic          led_reg;
    logic [31:0]   tick_reg;
    logic [31:0]   last_reg;
    // Match flags for each command word, cleared on mismatch while scanning.
    logic          m_on_reg, m_off_reg, m_bl_reg, m_help_reg, m_pre_reg;
    logic [1:0]    ph_reg;       // 0 space or sign, 2 digits, 3 stopped (1 unused)
    logic          neg_reg;
    logic [29:0]   mag_reg;
    logic          ev_reg, er_reg;
    logic [7:0]    ec_reg;
    logic [3:0]    resp_reg;

    logic          is_bs, is_end;
    logic [LW-1:0] pos;
    logic          sp, dg;
    logic [3:0]    dv;
    logic [33:0]   mul10;
    logic [33:0]   nmag;
    logic [7:0]    w_on, w_off, w_bl, w_help;

    assign is_bs  = (char_in == 8'd8) || (char_in == 8'd127);
    assign is_end = (char_in == 8'd13) || (char_in == 8'd10);
    assign pos    = idx_reg - LW'(1);
    assign sp     = (rd_reg == 8'd32) || (rd_reg >= 8'd9 && rd_reg <= 8'd13);
    assign dg     = (rd_reg >= 8'h30) && (rd_reg <= 8'h39);
    assign dv     = 4'(rd_reg - 8'h30);
    assign mul10  = {4'd0, mag_reg} * 34'd10;
    assign nmag   = mul10 + 34'(dv);

    always_comb
    begin
        w_on = 8'h00; w_off = 8'h00; w_bl = 8'h00; w_help = 8'h00;
        case (pos)
            LW'(0): begin w_on = "L"; w_off = "L"; w_bl = "B"; w_help = "H"; end
            LW'(1): begin w_on = "E"; w_off = "E"; w_bl = "L"; w_help = "E"; end
            LW'(2): begin w_on = "D"; w_off = "D"; w_bl = "I"; w_help = "L"; end
            LW'(3): begin w_on = "_"; w_off = "_"; w_bl = "N"; w_help = "P"; end
            LW'(4): begin w_on = "O"; w_off = "O"; w_bl = "K"; end
            LW'(5): begin w_on = "N"; w_off = "F"; w_bl = "_"; end
            LW'(6): begin w_off = "F"; end
            default: begin end
        endcase
    end

    assign st.scan_done = !end_reg || op_reg || (len_reg == '0)
                          || (rd_ok_reg && idx_reg == len_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.take && !op && !is_bs && !is_end && len_reg < LW'(LINE_DEPTH - 1))
        begin
            mem[len_reg] <= char_in;
        end
        rd_reg <= mem[idx_reg];
    end

    always_comb
    begin
        len_next = len_reg;
        if (!op)
        begin
            if (is_bs)
            begin
                if (len_reg != '0) len_next = len_reg - LW'(1);
            end
            else if (!is_end)
            begin
                len_next = (len_reg < LW'(LINE_DEPTH - 1)) ? len_reg + LW'(1) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            en_reg   <= 1'b0;
            per_reg  <= lcpbt_pkg::PERIOD_RESET;
            led_reg  <= 1'b0;
            tick_reg <= '0;
            last_reg <= '0;
            idx_reg  <= '0;
            rd_ok_reg <= 1'b0;
            op_reg   <= 1'b0;
            end_reg  <= 1'b0;
            ev_reg   <= 1'b0;
            er_reg   <= 1'b0;
            ec_reg   <= 8'd0;
            resp_reg <= lcpbt_pkg::RESP_NONE;
            m_on_reg <= 1'b0; m_off_reg <= 1'b0; m_bl_reg <= 1'b0;
            m_help_reg <= 1'b0; m_pre_reg <= 1'b0;
            ph_reg   <= 2'd0;
            neg_reg  <= 1'b0;
            mag_reg  <= '0;
        end
        else if (ctl.take)
        begin
            op_reg    <= op;
            end_reg   <= !op && is_end;
            idx_reg   <= '0;
            rd_ok_reg <= 1'b0;
            ev_reg    <= 1'b0;
            er_reg    <= 1'b0;
            ec_reg    <= 8'd0;
            resp_reg  <= lcpbt_pkg::RESP_NONE;
            m_on_reg  <= 1'b1; m_off_reg <= 1'b1; m_bl_reg <= 1'b1;
            m_help_reg <= 1'b1; m_pre_reg <= 1'b1;
            ph_reg    <= 2'd0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            if (op)
            begin
                tick_reg <= tick_reg + 32'd1;
            end
            else if (is_bs)
            begin
                er_reg <= len_reg != '0;
                len_reg <= len_next;
            end
            else if (!is_end)
            begin
                if (len_reg < LW'(LINE_DEPTH - 1))
                begin
                    ev_reg <= 1'b1;
                    ec_reg <= char_in;
                end
                else
                begin
                    resp_reg <= lcpbt_pkg::RESP_TOO_LONG;
                end
                len_reg <= len_next;
            end
        end
        else if (ctl.rd)
        begin
            if (!st.scan_done)
            begin
                idx_reg   <= idx_reg + LW'(1);
                rd_ok_reg <= 1'b1;
            end
            if (rd_ok_reg)
            begin
                if (rd_reg != w_on)   m_on_reg   <= 1'b0;
                if (rd_reg != w_off)  m_off_reg  <= 1'b0;
                if (rd_reg != w_bl)   m_bl_reg   <= 1'b0;
                if (rd_reg != w_help) m_help_reg <= 1'b0;
                if (pos < LW'(6) && rd_reg != w_bl) m_pre_reg <= 1'b0;
                if (pos >= LW'(6))
                begin
                    case (ph_reg)
                        2'd0:
                        begin
                            if (!sp)
                            begin
                                if (rd_reg == "+" || rd_reg == "-")
                                begin
                                    neg_reg <= rd_reg == "-";
                                    ph_reg  <= 2'd2;
                                end
                                else if (dg)
                                begin
                                    mag_reg <= 30'(dv);
                                    ph_reg  <= 2'd2;
                                end
                                else ph_reg <= 2'd3;
                            end
                        end
                        2'd2:
                        begin
                            if (dg)
                            begin
                                mag_reg <= (nmag > 34'(lcpbt_pkg::PERIOD_MAX))
                                           ? lcpbt_pkg::PERIOD_MAX : 30'(nmag);
                            end
                            else ph_reg <= 2'd3;
                        end
                        default: begin end
                    endcase
                end
            end
        end
        else if (ctl.finish)
        begin
            logic       e_n;
            logic       l_n;
            logic [29:0] p_n;
            e_n = en_reg;
            l_n = led_reg;
            p_n = per_reg;
            if (end_reg)
            begin
                if (len_reg == '0)
                begin
                    resp_reg <= lcpbt_pkg::RESP_PROMPT;
                end
                else
                begin
                    len_reg <= '0;
                    if (m_on_reg && len_reg == LW'(6))
                    begin
                        e_n = 1'b0; l_n = 1'b1; resp_reg <= lcpbt_pkg::RESP_LED_ON;
                    end
                    else if (m_off_reg && len_reg == LW'(7))
                    begin
                        e_n = 1'b0; l_n = 1'b0; resp_reg <= lcpbt_pkg::RESP_LED_OFF;
                    end
                    else if (m_pre_reg && len_reg >= LW'(6))
                    begin
                        if (!neg_reg && mag_reg > 30'd10)
                        begin
                            p_n = mag_reg; e_n = 1'b1;
                            resp_reg <= lcpbt_pkg::RESP_INTERVAL;
                        end
                        else resp_reg <= lcpbt_pkg::RESP_TOO_FAST;
                    end
                    else if (m_bl_reg && len_reg == LW'(5))
                    begin
                        e_n = 1'b1; resp_reg <= lcpbt_pkg::RESP_BLINK_ON;
                    end
                    else if (m_help_reg && len_reg == LW'(4))
                    begin
                        resp_reg <= lcpbt_pkg::RESP_HELP;
                    end
                    else resp_reg <= lcpbt_pkg::RESP_UNKNOWN;
                end
            end
            if (e_n && (tick_reg - last_reg) >= {2'b00, p_n})
            begin
                last_reg <= tick_reg;
                l_n = !l_n;
            end
            en_reg  <= e_n;
            led_reg <= l_n;
            per_reg <= p_n;
        end
    end

    assign echo_valid     = ev_reg;
    assign echo_char      = ec_reg;
    assign erase          = er_reg;
    assign response       = resp_reg;
    assign interval_value = per_reg;
    assign led            = led_reg;

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(LINE_DEPTH - 1))
        else $error("line length out of range");
    a_echo_len: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take && !op && !is_bs && !is_end && len_reg < LW'(LINE_DEPTH - 1)
        |=> ev_reg && len_reg == $past(len_reg) + LW'(1))
        else $error("echo without store");
    a_per_min: assert property (@(posedge clk) disable iff (!rst_n)
        per_reg > 30'd10)
        else $error("period too small");

endmodule
`default_nettype wire

// ===== sv/line_command_parser_blink_timer.sv =====
// Sequence: a tick, plain character or empty line end is accepted in idle, then passes the scan,
// finish and output states; a non-empty line end scans the stored line one character a cycle.
// Throughput: one item at a time; the next item is accepted only after the result is taken.
// Reset: asynchronous active-low; empty line, LED off, blinking off, period 500 ms.
`default_nettype none
module line_command_parser_blink_timer
#(
    parameter int LINE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  char_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             echo_valid,
    output logic [7:0]       echo_char,
    output logic             erase,
    output logic [3:0]       response,
    output logic [29:0]      interval_value,
    output logic             led
);

    lcpbt_pkg::ctrl_t ctl;
    lcpbt_pkg::stat_t st;
    logic             in_ready;
    logic             out_busy;
    logic             in_acc;
    logic             out_acc;

    assign in_stall  = !in_ready;
    assign out_valid = out_busy;
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_busy && !out_stall;

    lcpbt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_acc   (in_acc),
        .out_acc  (out_acc),
        .st       (st),
        .ctl      (ctl),
        .in_ready (in_ready),
        .out_busy (out_busy)
    );

    lcpbt_dp #(.LINE_DEPTH(LINE_DEPTH)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .op             (op),
        .char_in        (char_in),
        .st             (st),
        .echo_valid     (echo_valid),
        .echo_char      (echo_char),
        .erase          (erase),
        .response       (response),
        .interval_value (interval_value),
        .led            (led)
    );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the line command parser and LED blink timer.
`default_nettype none
module testbench;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 5000;
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              echo_valid;
        logic [7:0]        echo_char;
        logic              erase;
        lcpbt_pkg::resp_t  response;
        logic [29:0]       interval_value;
        logic              led;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [7:0]  char_in;
    logic        out_valid;
    logic        out_stall;
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic        erase;
    logic [3:0]  response;
    logic [29:0] interval_value;
    logic        led;

    line_command_parser_blink_timer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .char_in(char_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .echo_valid(echo_valid), .echo_char(echo_char), .erase(erase),
        .response(response), .interval_value(interval_value), .led(led)
    );

    logic [7:0]  line_buf [DEPTH];
    int unsigned line_len;
    logic        blinking;
    logic [29:0] period;
    logic        led_lvl;
    logic [31:0] ticks;
    logic [31:0] last_toggle;

    outcome_t    pending[$];
    int          errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit line_equals(string word);
        if (line_len != word.len())
            return 0;
        for (int i = 0; i < word.len(); i++)
            if (line_buf[i] != word[i])
                return 0;
        return 1;
    endfunction

    function automatic lcpbt_pkg::resp_t execute_line();
        string             pfx;
        int unsigned       i;
        int unsigned       mag;
        bit                neg;
        bit                is_blink_arg;
        lcpbt_pkg::resp_t  r;
        pfx = "BLINK_";
        is_blink_arg = line_len >= 6;
        for (int k = 0; k < 6; k++)
            if (is_blink_arg && line_buf[k] != pfx[k])
                is_blink_arg = 0;
        if (line_equals("LED_ON"))
        begin
            blinking = 0;
            led_lvl = 1;
            r = lcpbt_pkg::RESP_LED_ON;
        end
        else if (line_equals("LED_OFF"))
        begin
            blinking = 0;
            led_lvl = 0;
            r = lcpbt_pkg::RESP_LED_OFF;
        end
        else if (is_blink_arg)
        begin
            i = 6;
            mag = 0;
            neg = 0;
            while (i < line_len
                   && (line_buf[i] == 32 || (line_buf[i] >= 9 && line_buf[i] <= 13)))
                i++;
            if (i < line_len && (line_buf[i] == "+" || line_buf[i] == "-"))
            begin
                neg = line_buf[i] == "-";
                i++;
            end
            while (i < line_len && line_buf[i] >= "0" && line_buf[i] <= "9")
            begin
                if (mag > (32'(lcpbt_pkg::PERIOD_MAX) - (line_buf[i] - "0")) / 10)
                    mag = 32'(lcpbt_pkg::PERIOD_MAX);
                else
                    mag = mag * 10 + (line_buf[i] - "0");
                i++;
            end
            if (!neg && mag > 10)
            begin
                period = 30'(mag);
                blinking = 1;
                r = lcpbt_pkg::RESP_INTERVAL;
            end
            else
                r = lcpbt_pkg::RESP_TOO_FAST;
        end
        else if (line_equals("BLINK"))
        begin
            blinking = 1;
            r = lcpbt_pkg::RESP_BLINK_ON;
        end
        else if (line_equals("HELP"))
            r = lcpbt_pkg::RESP_HELP;
        else
            r = lcpbt_pkg::RESP_UNKNOWN;
        line_len = 0;
        return r;
    endfunction

    function automatic outcome_t predict_step(logic is_tick, logic [7:0] c);
        outcome_t o;
        o = '0;
        o.response = lcpbt_pkg::RESP_NONE;
        if (is_tick)
            ticks++;
        else if (c == 8'd8 || c == 8'd127)
        begin
            if (line_len > 0)
            begin
                line_len--;
                o.erase = 1;
            end
        end
        else if (c == 8'd13 || c == 8'd10)
            o.response = (line_len > 0) ? execute_line() : lcpbt_pkg::RESP_PROMPT;
        else if (line_len < DEPTH - 1)
        begin
            o.echo_valid = 1;
            o.echo_char = c;
            line_buf[line_len] = c;
            line_len++;
        end
        else
        begin
            o.response = lcpbt_pkg::RESP_TOO_LONG;
            line_len = 0;
        end
        if (blinking && (ticks - last_toggle) >= {2'b00, period})
        begin
            last_toggle = ticks;
            led_lvl = ~led_lvl;
        end
        o.interval_value = period;
        o.led = led_lvl;
        return o;
    endfunction

    task automatic send_item(logic is_tick, logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            op <= 1'($urandom_range(1));
            char_in <= 8'($urandom_range(255));
            @(negedge clk);
        end
        op <= is_tick;
        char_in <= c;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending.push_back(predict_step(is_tick, c));
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(OP_CHAR, s[i]);
    endtask

    task automatic send_line(string s);
        send_text(s);
        send_item(OP_CHAR, 8'd13);
    endtask

    task automatic send_ticks(int n);
        for (int i = 0; i < n; i++)
            send_item(OP_TICK, 8'($urandom_range(255)));
    endtask

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
            begin
                $error("result arrived with no expected item");
                errors++;
            end
            else
            begin
                outcome_t e;
                e = pending.pop_front();
                if (echo_valid !== e.echo_valid)
                begin
                    $error("echo_valid expected %0d actual %0d", e.echo_valid, echo_valid);
                    errors++;
                end
                if (echo_char !== e.echo_char)
                begin
                    $error("echo_char expected %0d actual %0d", e.echo_char, echo_char);
                    errors++;
                end
                if (erase !== e.erase)
                begin
                    $error("erase expected %0d actual %0d", e.erase, erase);
                    errors++;
                end
                if (response !== e.response)
                begin
                    $error("response expected %0d actual %0d", e.response, response);
                    errors++;
                end
                if (interval_value !== e.interval_value)
                begin
                    $error("interval_value expected %0d actual %0d",
                           e.interval_value, interval_value);
                    errors++;
                end
                if (led !== e.led)
                begin
                    $error("led expected %0d actual %0d", e.led, led);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] random_byte();
        case ($urandom_range(9))
            0: return 8'($urandom_range(255));
            1: return ($urandom_range(1) != 0) ? 8'd8 : 8'd127;
            2: return ($urandom_range(1) != 0) ? 8'd13 : 8'd10;
            3, 4: return 8'("0" + $urandom_range(9));
            5: return ($urandom_range(1) != 0) ? "+" : "-";
            6: return ($urandom_range(1) != 0) ? 8'd32 : 8'(9 + $urandom_range(4));
            default: return 8'("A" + $urandom_range(25));
        endcase
    endfunction

    function automatic string random_command();
        string s;
        case ($urandom_range(7))
            0: s = "LED_ON";
            1: s = "LED_OFF";
            2: s = "BLINK";
            3: s = "HELP";
            4: s = $sformatf("BLINK_%0d", 11 + $urandom_range(40));
            5: s = $sformatf("BLINK_%0d", $urandom_range(20));
            6:
            begin
                s = "BLINK_";
                for (int i = 0; i < $urandom_range(9); i++)
                    s = {s, string'(random_byte())};
            end
            default:
            begin
                s = "";
                for (int i = 0; i < $urandom_range(1, 8); i++)
                    s = {s, string'(random_byte())};
            end
        endcase
        return s;
    endfunction

    task automatic test_commands();
        send_item(OP_CHAR, 8'd13);
        send_item(OP_CHAR, 8'd127);
        send_line("HELP");
        send_line("LED_ON");
        send_line("LED_OFF");
        send_line("BLINK");
        send_ticks(3);
        send_line("XY");
    endtask

    task automatic test_blink_args();
        send_line("BLINK_10");
        send_line("BLINK_-50");
        send_line("BLINK_ \t+12");
        send_line("BLINK_99999999999");
        send_line("BLINK_x");
        send_line("BLINK_11");
        send_ticks(25);
    endtask

    task automatic test_edit_and_overflow();
        send_text("LED_OX");
        send_item(OP_CHAR, 8'd8);
        send_line("N");
        send_text("LED_O");
        send_item(OP_CHAR, 8'h00);
        send_item(OP_CHAR, 8'd10);
        send_text("ABCDEFGHIJKLMNO");
        send_item(OP_CHAR, 8'hFF);
        send_item(OP_CHAR, 8'd13);
    endtask

    task automatic test_random(int n);
        int sent;
        sent = 0;
        while (sent < n)
        begin
            int r;
            r = $urandom_range(9);
            if (r < 5)
            begin
                string s;
                s = random_command();
                send_line(s);
                sent += s.len() + 1;
            end
            else if (r < 8)
            begin
                int k;
                k = $urandom_range(1, 30);
                send_ticks(k);
                sent += k;
            end
            else
            begin
                send_item(1'($urandom_range(1)), random_byte());
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = 1'b0;
        char_in = 8'd0;
        out_stall = 1'b0;
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 32;
        recv_idle_pct = 48;
        line_len = 0;
        blinking = 0;
        period = lcpbt_pkg::PERIOD_RESET;
        led_lvl = 0;
        ticks = 0;
        last_toggle = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_commands();
        test_blink_args();
        test_edit_and_overflow();
        test_random(400);
        send_idle_pct = 48;
        recv_idle_pct = 32;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        in_valid <= 1'b0;

        while (pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/lcpbt_pkg.sv
sv/lcpbt_ctrl.sv
sv/lcpbt_dp.sv
sv/line_command_parser_blink_timer.sv
tb/testbench.sv
